>>> hw/rtl/nss_pkg.sv
// ----------------------------------------------------------------------------
// Nearest symbol slicer package
// Command and status codes, default sizes and the controller-to-datapath
// command bundle.
// ----------------------------------------------------------------------------
package nss_pkg;

  localparam int DEF_MAX_POINTS = 256;
  localparam int DEF_COORD_BITS = 16;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SLICE  = 2'd2;

  localparam logic [1:0] STAT_DECIDED = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_STORED  = 2'd2;
  localparam logic [1:0] STAT_DROPPED = 2'd3;

  typedef struct packed {
    logic load_sample;  // capture the sample to slice
    logic wr_en;        // store the offered point at the fill position
    logic rd_en;        // read one table entry into the distance pipe
    logic rd_first;     // this entry is the first of the scan
    logic clr_out;      // force the decided point to zero
  } nss_cmd_t;

endpackage

>>> hw/rtl/nss_ctrl.sv
// ----------------------------------------------------------------------------
// Nearest symbol slicer controller
// Accepts commands, keeps the point count, walks the table index during a
// slice and issues the result strobe and status.
// ----------------------------------------------------------------------------
module nss_ctrl #(
  parameter int MAX_POINTS = nss_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [1:0]                          cmd,
  input  logic                                pipe_busy,
  output logic                                busy,
  output nss_pkg::nss_cmd_t                   dp_cmd,
  output logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
  output logic [$clog2(MAX_POINTS)-1:0]       wr_addr,
  output logic                                done,
  output logic [1:0]                          status
);
  import nss_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  logic          done_next;
  logic [1:0]    status_next;
  logic          accept;
  logic          last_idx;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign rd_addr  = idx;
  assign wr_addr  = count[AW-1:0];
  assign last_idx = ({1'b0, idx} == (count - CW'(1)));

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    done_next   = 1'b0;
    status_next = status;
    dp_cmd      = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_CLEAR: begin
              count_next     = '0;
              done_next      = 1'b1;
              status_next    = STAT_STORED;
              dp_cmd.clr_out = 1'b1;
            end
            CMD_APPEND: begin
              done_next      = 1'b1;
              dp_cmd.clr_out = 1'b1;
              if (count < CW'(MAX_POINTS)) begin
                dp_cmd.wr_en = 1'b1;
                count_next   = count + CW'(1);
                status_next  = STAT_STORED;
              end else begin
                status_next  = STAT_DROPPED;
              end
            end
            CMD_SLICE: begin
              if (count == '0) begin
                done_next      = 1'b1;
                status_next    = STAT_EMPTY;
                dp_cmd.clr_out = 1'b1;
              end else begin
                dp_cmd.load_sample = 1'b1;
                idx_next           = '0;
                state_next         = S_SCAN;
              end
            end
            default: begin
              done_next      = 1'b1;
              status_next    = STAT_DROPPED;
              dp_cmd.clr_out = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        dp_cmd.rd_en    = 1'b1;
        dp_cmd.rd_first = (idx == '0);
        idx_next        = idx + AW'(1);
        if (last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The decision is final once the last distance has left the pipe.
        if (!pipe_busy) begin
          done_next   = 1'b1;
          status_next = STAT_DECIDED;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      status <= STAT_STORED;
      idx    <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      done   <= done_next;
      status <= status_next;
      idx    <= idx_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, idx} < count))
    else $error("scan index beyond stored points");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && accept && (cmd == CMD_SLICE) && (count != '0) |=>
    (state == S_SCAN))
    else $error("slice of filled table did not start a scan");

endmodule

>>> hw/rtl/nss_dp.sv
// ----------------------------------------------------------------------------
// Nearest symbol slicer datapath
// Point table memory, a four-stage squared-distance pipe and the running
// nearest-point register.
// ----------------------------------------------------------------------------
module nss_dp #(
  parameter int MAX_POINTS = nss_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = nss_pkg::DEF_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  nss_pkg::nss_cmd_t               dp_cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
  input  logic [COORD_BITS-1:0]           point_i,
  input  logic [COORD_BITS-1:0]           point_q,
  input  logic [COORD_BITS-1:0]           sample_i,
  input  logic [COORD_BITS-1:0]           sample_q,
  output logic                            pipe_busy,
  output logic [COORD_BITS-1:0]           decided_i,
  output logic [COORD_BITS-1:0]           decided_q
);
  import nss_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;          // difference width
  localparam int SW = 2 * DW;          // square width
  localparam int TW = SW + 1;          // distance width

  logic [2*CB-1:0] mem [MAX_POINTS];

  logic [CB-1:0] smp_i, smp_q;

  // Stage 1: table read.
  logic          v1, f1;
  logic [CB-1:0] p1_i, p1_q;
  // Stage 2: absolute differences.
  logic          v2, f2;
  logic [CB-1:0] p2_i, p2_q;
  logic [DW-1:0] ad_i, ad_q;
  // Stage 3: squares.
  logic          v3, f3;
  logic [CB-1:0] p3_i, p3_q;
  logic [SW-1:0] sq_i, sq_q;
  // Stage 4: distance.
  logic          v4, f4;
  logic [CB-1:0] p4_i, p4_q;
  logic [TW-1:0] dist_sum;

  logic [TW-1:0] best_d;
  logic [CB-1:0] best_i, best_q;

  logic [DW-1:0] diff_i, diff_q;

  assign diff_i = {p1_i[CB-1], p1_i} - {smp_i[CB-1], smp_i};
  assign diff_q = {p1_q[CB-1], p1_q} - {smp_q[CB-1], smp_q};

  assign pipe_busy = v1 | v2 | v3 | v4;
  assign decided_i = best_i;
  assign decided_q = best_q;

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en) begin
      mem[wr_addr] <= {point_i, point_q};
    end
    if (dp_cmd.rd_en) begin
      {p1_i, p1_q} <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= dp_cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_sample) begin
      smp_i <= sample_i;
      smp_q <= sample_q;
    end
    f1   <= dp_cmd.rd_first;
    f2   <= f1;
    p2_i <= p1_i;
    p2_q <= p1_q;
    ad_i <= diff_i[DW-1] ? (~diff_i + DW'(1)) : diff_i;
    ad_q <= diff_q[DW-1] ? (~diff_q + DW'(1)) : diff_q;
    f3   <= f2;
    p3_i <= p2_i;
    p3_q <= p2_q;
    sq_i <= SW'(ad_i) * SW'(ad_i);
    sq_q <= SW'(ad_q) * SW'(ad_q);
    f4   <= f3;
    p4_i <= p3_i;
    p4_q <= p3_q;
    dist_sum <= TW'(sq_i) + TW'(sq_q);
  end

  // Strictly smaller distance replaces the best, so the earliest point wins a tie.
  always_ff @(posedge clk) begin
    if (rst || dp_cmd.clr_out) begin
      best_i <= '0;
      best_q <= '0;
    end else if (v4 && (f4 || (dist_sum < best_d))) begin
      best_i <= p4_i;
      best_q <= p4_q;
    end
    if (v4 && (f4 || (dist_sum < best_d))) begin
      best_d <= dist_sum;
    end
  end

endmodule

>>> hw/rtl/nearest_symbol_slicer_core.sv
// ----------------------------------------------------------------------------
// Nearest symbol slicer core
// Minimum-distance hard-decision slicer over a loaded constellation table.
// ----------------------------------------------------------------------------
//  Channel   Ports                                      Handshake
//  command   cmd, point_i, point_q, sample_i, sample_q  start & !busy
//  result    decided_i, decided_q, status               done, one cycle
//
//  Clear, append and an empty-table slice answer in the cycle after the beat
//  and leave busy low, so such commands can follow every cycle.
//  A slice holds busy while it reads each stored point, one table read per
//  cycle through the single memory read port, then while four pipe stages drain.
//  Reset empties the table at once; the table memory itself is not cleared.
//  The receiver cannot stall; each result beat is shown for one cycle.
// ----------------------------------------------------------------------------
module nearest_symbol_slicer_core #(
  parameter int MAX_POINTS = nss_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = nss_pkg::DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd,
  input  logic [COORD_BITS-1:0] point_i,
  input  logic [COORD_BITS-1:0] point_q,
  input  logic [COORD_BITS-1:0] sample_i,
  input  logic [COORD_BITS-1:0] sample_q,
  output logic                  done,
  output logic [COORD_BITS-1:0] decided_i,
  output logic [COORD_BITS-1:0] decided_q,
  output logic [1:0]            status
);
  import nss_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  nss_cmd_t      dp_cmd;
  logic          pipe_busy;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  nss_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .pipe_busy(pipe_busy),
    .busy     (busy),
    .dp_cmd   (dp_cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .done     (done),
    .status   (status)
  );

  nss_dp #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .dp_cmd   (dp_cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .point_i  (point_i),
    .point_q  (point_q),
    .sample_i (sample_i),
    .sample_q (sample_q),
    .pipe_busy(pipe_busy),
    .decided_i(decided_i),
    .decided_q(decided_q)
  );

endmodule
